// ----- sv/stgs_pkg.sv -----
// Shared types, sizes and codes of the sentiment-topic Gibbs sampler.
`default_nettype none
package stgs_pkg;

    localparam int MAX_LABELS = 3;
    localparam int MAX_TOPICS = 64;
    localparam int VOCAB_SIZE = 4096;
    localparam int MAX_DOCS   = 1024;
    localparam int COUNT_BITS = 20;
    localparam int LT_BITS    = 24;

    localparam int LBL_W  = 2;
    localparam int TOP_W  = 6;
    localparam int NT_W   = 7;
    localparam int DOC_W  = 10;
    localparam int WORD_W = 12;
    localparam int FRAC_W = 16;
    localparam int PRI_W  = 24;
    localparam int BETA_W = 32;
    localparam int SUM_W  = 24;

    localparam int DL_DEPTH  = MAX_DOCS * MAX_LABELS;
    localparam int DL_W      = 12;
    localparam int DLT_DEPTH = DL_DEPTH * MAX_TOPICS;
    localparam int DLT_W     = DL_W + TOP_W;
    localparam int LT_DEPTH  = MAX_LABELS * MAX_TOPICS;
    localparam int LT_W      = LBL_W + TOP_W;
    localparam int WLT_DEPTH = LT_DEPTH * VOCAB_SIZE;
    localparam int WLT_W     = LT_W + WORD_W;
    localparam int CLR_W     = WLT_W;

    localparam int DIV_W   = 42;
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_LABEL_COUNT = 3'd0,
        REG_TOPIC_COUNT = 3'd1,
        REG_ALPHA       = 3'd2,
        REG_GAMMA       = 3'd3,
        REG_BETA0       = 3'd4,
        REG_BETA1       = 3'd5,
        REG_BETA2       = 3'd6
    } t_reg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CNT_RD,
        OP_CNT_DN,
        OP_CNT_UP,
        OP_LBL_RD,
        OP_LBL_DIV,
        OP_LBL_SAVE,
        OP_TOP_RD,
        OP_TOP_DIV,
        OP_MUL1,
        OP_MUL2,
        OP_ACC,
        OP_WPS_RD,
        OP_DRAW,
        OP_PICK,
        OP_OUT,
        OP_CLR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [LBL_W-1:0] lbl;
        logic [TOP_W-1:0] top;
        logic [CLR_W-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic hit;
    } t_sts;

    typedef struct packed {
        logic [LBL_W-1:0]  nl;
        logic [NT_W-1:0]   nt;
        logic [PRI_W-1:0]  alpha;
        logic [PRI_W-1:0]  gamma;
        logic [BETA_W-1:0] beta0;
        logic [BETA_W-1:0] beta1;
        logic [BETA_W-1:0] beta2;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [DOC_W-1:0]  doc_index;
        logic [WORD_W-1:0] word_id;
        logic [LBL_W-1:0]  old_label;
        logic [TOP_W-1:0]  old_topic;
        logic [PRI_W-1:0]  word_beta_label0;
        logic [PRI_W-1:0]  word_beta_label1;
        logic [PRI_W-1:0]  word_beta_label2;
        logic [FRAC_W-1:0] random_fraction;
    } t_in_item;

    typedef struct packed {
        logic [LBL_W-1:0] new_label;
        logic [TOP_W-1:0] new_topic;
    } t_out_item;

endpackage
`default_nettype wire

// ----- sv/stgs_div.sv -----
// Restoring divider giving a saturated Q0.16 quotient, one bit per cycle.
`default_nettype none
module stgs_div import stgs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_num,
    input  wire logic [DIV_W-1:0]  i_den,
    output logic                   o_done,
    output logic [FRAC_W-1:0]      o_quot
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_quot;
    logic              r_sat;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  n_shift;

    assign n_shift = {r_rem[DIV_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
            r_sat  <= (i_num >= i_den);
        end else if (r_busy) begin
            if (n_shift >= r_den) begin
                r_rem  <= n_shift - r_den;
                r_quot <= {r_quot[FRAC_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_quot <= {r_quot[FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? {FRAC_W{1'b1}} : r_quot;

endmodule
`default_nettype wire

// ----- sv/stgs_datapath.sv -----
// Count memories, ratio dividers, weight multipliers and draw logic.
`default_nettype none
module stgs_datapath import stgs_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_cfg      i_cfg,
    input  wire t_in_item  i_item,
    output t_sts           o_sts,
    output t_out_item      o_out_item
);

    logic [COUNT_BITS-1:0] r_dtc_mem [MAX_DOCS];
    logic [COUNT_BITS-1:0] r_dlc_mem [DL_DEPTH];
    logic [COUNT_BITS-1:0] r_dlt_mem [DLT_DEPTH];
    logic [COUNT_BITS-1:0] r_wlt_mem [WLT_DEPTH];
    logic [LT_BITS-1:0]    r_lt_mem  [LT_DEPTH];
    logic [SUM_W-1:0]      r_wps_mem [LT_DEPTH];

    logic [COUNT_BITS-1:0] r_dtc_q, r_dlc_q, r_dlt_q, r_wlt_q;
    logic [LT_BITS-1:0]    r_lt_q;
    logic [SUM_W-1:0]      r_wps_q;

    logic [DOC_W-1:0]      r_d;
    logic [WORD_W-1:0]     r_w;
    logic [LBL_W-1:0]      r_lab;
    logic [TOP_W-1:0]      r_top;
    logic [PRI_W-1:0]      r_wb0, r_wb1, r_wb2;
    logic [FRAC_W-1:0]     r_rf;
    logic [NT_W+PRI_W-1:0] r_ntalpha;
    logic [LBL_W+PRI_W-1:0] r_nlgamma;
    logic [DIV_W-1:0]      r_adn;
    logic [FRAC_W-1:0]     r_r3, r_p1, r_wt;
    logic [SUM_W-1:0]      r_run, r_u;
    t_out_item             r_out;
    logic                  r_lbl_div;

    logic                  cnt_op, re_cnt, we_cnt, up;
    logic [LBL_W-1:0]      sel_l;
    logic [TOP_W-1:0]      sel_t;
    logic [DOC_W-1:0]      a_dtc;
    logic [DL_W-1:0]       dl_idx, a_dl;
    logic [DLT_W-1:0]      a_dlt;
    logic [WLT_W-1:0]      a_wlt;
    logic [LT_W-1:0]       a_lt;
    logic                  we_dtc, we_dl, we_dlt, we_wlt, we_lt;
    logic [COUNT_BITS-1:0] wd_dtc, wd_dl, wd_dlt, wd_wlt;
    logic [LT_BITS-1:0]    wd_lt;
    logic [PRI_W-1:0]      wbeta_sel;
    logic [BETA_W-1:0]     beta_sel;
    logic [DIV_W-1:0]      num_a, den_a, num_b;
    logic                  start_a, start_b;
    logic                  done_a, done_b;
    logic [FRAC_W-1:0]     quot_a, quot_b;
    logic [2*FRAC_W-1:0]   prod1, prod2;
    logic [FRAC_W+SUM_W-1:0] prod3;
    logic [SUM_W-1:0]      run_next;
    logic [LBL_W-1:0]      lab_clamp;
    logic [TOP_W-1:0]      top_clamp;

    function automatic logic [COUNT_BITS-1:0] bump_cnt(input logic [COUNT_BITS-1:0] c,
                                                       input logic inc);
        logic [COUNT_BITS-1:0] res;
        res = c;
        if (inc) begin
            if (c != {COUNT_BITS{1'b1}}) res = c + 1'b1;
        end else begin
            if (c != '0) res = c - 1'b1;
        end
        return res;
    endfunction

    function automatic logic [LT_BITS-1:0] bump_lt(input logic [LT_BITS-1:0] c, input logic inc);
        logic [LT_BITS-1:0] res;
        res = c;
        if (inc) begin
            if (c != {LT_BITS{1'b1}}) res = c + 1'b1;
        end else begin
            if (c != '0) res = c - 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        cnt_op = (i_cmd.op == OP_CNT_RD) || (i_cmd.op == OP_CNT_DN) ||
                 (i_cmd.op == OP_CNT_UP);
        re_cnt = (i_cmd.op == OP_CNT_RD) || (i_cmd.op == OP_LBL_RD) ||
                 (i_cmd.op == OP_TOP_RD);
        we_cnt = (i_cmd.op == OP_CNT_DN) || (i_cmd.op == OP_CNT_UP);
        up     = (i_cmd.op == OP_CNT_UP);
        sel_l  = cnt_op ? r_lab : i_cmd.lbl;
        sel_t  = cnt_op ? r_top : i_cmd.top;
        dl_idx = DL_W'(r_d) * DL_W'(MAX_LABELS) + DL_W'(sel_l);
        if (i_cmd.op == OP_CLR) begin
            a_dtc  = i_cmd.clr_addr[DOC_W-1:0];
            a_dl   = i_cmd.clr_addr[DL_W-1:0];
            a_dlt  = i_cmd.clr_addr[DLT_W-1:0];
            a_wlt  = i_cmd.clr_addr[WLT_W-1:0];
            a_lt   = i_cmd.clr_addr[LT_W-1:0];
            we_dtc = (i_cmd.clr_addr < CLR_W'(MAX_DOCS));
            we_dl  = (i_cmd.clr_addr < CLR_W'(DL_DEPTH));
            we_dlt = (i_cmd.clr_addr < CLR_W'(DLT_DEPTH));
            we_wlt = 1'b1;
            we_lt  = (i_cmd.clr_addr < CLR_W'(LT_DEPTH));
            wd_dtc = '0;
            wd_dl  = '0;
            wd_dlt = '0;
            wd_wlt = '0;
            wd_lt  = '0;
        end else begin
            a_dtc  = r_d;
            a_dl   = dl_idx;
            a_dlt  = {dl_idx, sel_t};
            a_wlt  = {sel_l, sel_t, r_w};
            a_lt   = {sel_l, sel_t};
            we_dtc = we_cnt;
            we_dl  = we_cnt;
            we_dlt = we_cnt;
            we_wlt = we_cnt;
            we_lt  = we_cnt;
            wd_dtc = bump_cnt(r_dtc_q, up);
            wd_dl  = bump_cnt(r_dlc_q, up);
            wd_dlt = bump_cnt(r_dlt_q, up);
            wd_wlt = bump_cnt(r_wlt_q, up);
            wd_lt  = bump_lt(r_lt_q, up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_dtc) r_dtc_mem[a_dtc] <= wd_dtc;
        if (re_cnt) r_dtc_q <= r_dtc_mem[a_dtc];
    end

    always_ff @(posedge i_clk) begin
        if (we_dl) r_dlc_mem[a_dl] <= wd_dl;
        if (re_cnt) r_dlc_q <= r_dlc_mem[a_dl];
    end

    always_ff @(posedge i_clk) begin
        if (we_dlt) r_dlt_mem[a_dlt] <= wd_dlt;
        if (re_cnt) r_dlt_q <= r_dlt_mem[a_dlt];
    end

    always_ff @(posedge i_clk) begin
        if (we_wlt) r_wlt_mem[a_wlt] <= wd_wlt;
        if (re_cnt) r_wlt_q <= r_wlt_mem[a_wlt];
    end

    always_ff @(posedge i_clk) begin
        if (we_lt) r_lt_mem[a_lt] <= wd_lt;
        if (re_cnt) r_lt_q <= r_lt_mem[a_lt];
    end

    assign run_next = r_run + SUM_W'(r_wt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACC) r_wps_mem[a_lt] <= run_next;
        if (i_cmd.op == OP_WPS_RD) r_wps_q <= r_wps_mem[a_lt];
    end

    // labels above two share the label-2 priors
    always_comb begin
        case (i_cmd.lbl)
            2'd0: begin
                wbeta_sel = r_wb0;
                beta_sel  = i_cfg.beta0;
            end
            2'd1: begin
                wbeta_sel = r_wb1;
                beta_sel  = i_cfg.beta1;
            end
            default: begin
                wbeta_sel = r_wb2;
                beta_sel  = i_cfg.beta2;
            end
        endcase
        if (i_cmd.op == OP_LBL_DIV) begin
            num_a = (DIV_W'(r_dlc_q) << 16) + DIV_W'(i_cfg.gamma);
            den_a = (DIV_W'(r_dtc_q) << 16) + DIV_W'(r_nlgamma);
        end else begin
            num_a = (DIV_W'(r_wlt_q) << 16) + DIV_W'(wbeta_sel);
            den_a = (DIV_W'(r_lt_q) << 16) + DIV_W'(beta_sel);
        end
        num_b   = (DIV_W'(r_dlt_q) << 16) + DIV_W'(i_cfg.alpha);
        start_a = (i_cmd.op == OP_LBL_DIV) || (i_cmd.op == OP_TOP_DIV);
        start_b = (i_cmd.op == OP_TOP_DIV);
    end

    stgs_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_a),
        .i_num   (num_a),
        .i_den   (den_a),
        .o_done  (done_a),
        .o_quot  (quot_a)
    );

    stgs_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_b),
        .i_num   (num_b),
        .i_den   (r_adn),
        .o_done  (done_b),
        .o_quot  (quot_b)
    );

    assign prod1 = quot_a * quot_b;
    assign prod2 = r_p1 * r_r3;
    assign prod3 = r_rf * r_wps_q;

    // clamp the given pair into the active label and topic range
    always_comb begin
        lab_clamp = (i_item.old_label >= i_cfg.nl) ? (i_cfg.nl - 2'd1) : i_item.old_label;
        top_clamp = ({1'b0, i_item.old_topic} >= i_cfg.nt) ? TOP_W'(i_cfg.nt - 7'd1)
                                                           : i_item.old_topic;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_d       <= i_item.doc_index;
                r_w       <= i_item.word_id;
                r_lab     <= lab_clamp;
                r_top     <= top_clamp;
                r_wb0     <= i_item.word_beta_label0;
                r_wb1     <= i_item.word_beta_label1;
                r_wb2     <= i_item.word_beta_label2;
                r_rf      <= i_item.random_fraction;
                r_ntalpha <= (NT_W+PRI_W)'(i_cfg.nt) * (NT_W+PRI_W)'(i_cfg.alpha);
                r_nlgamma <= (LBL_W+PRI_W)'(i_cfg.nl) * (LBL_W+PRI_W)'(i_cfg.gamma);
                r_run     <= '0;
            end
            OP_LBL_SAVE: begin
                r_r3  <= quot_a;
                r_adn <= (DIV_W'(r_dlc_q) << 16) + DIV_W'(r_ntalpha);
            end
            OP_MUL1: r_p1 <= prod1[2*FRAC_W-1:FRAC_W];
            OP_MUL2: r_wt <= prod2[2*FRAC_W-1:FRAC_W];
            OP_ACC:  r_run <= run_next;
            OP_DRAW: r_u <= prod3[FRAC_W+SUM_W-1:FRAC_W];
            OP_PICK: begin
                r_lab <= i_cmd.lbl;
                r_top <= i_cmd.top;
            end
            OP_OUT: begin
                r_out.new_label <= r_lab;
                r_out.new_topic <= r_top;
            end
            default: ;
        endcase
    end

    // the label ratio runs on divider A alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbl_div <= 1'b0;
        end else if (start_a) begin
            r_lbl_div <= (i_cmd.op == OP_LBL_DIV);
        end
    end

    assign o_sts.div_done = done_a && (r_lbl_div || done_b);
    assign o_sts.hit      = (r_wps_q > r_u);
    assign o_out_item     = r_out;

endmodule
`default_nettype wire

// ----- sv/stgs_ctrl.sv -----
// Sequencer for clearing, count updates, the weight walk and the draw scan.
`default_nettype none
module stgs_ctrl import stgs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_action,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    input  wire logic [LBL_W-1:0] i_nl,
    input  wire logic [NT_W-1:0]  i_nt,
    input  wire logic             i_div_done,
    input  wire t_sts             i_sts,
    output t_cmd                  o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_WR,
        S_LBL_RD, S_LBL_DIV, S_LBL_WAIT, S_LBL_SAVE,
        S_TOP_RD, S_TOP_DIV, S_TOP_WAIT, S_MUL1, S_MUL2, S_ACC,
        S_LAST_RD, S_DRAW, S_SCAN_RD, S_SCAN_CHK, S_PICK, S_FINISH
    } t_state;

    t_state           r_state;
    logic [LBL_W-1:0] r_l;
    logic [TOP_W-1:0] r_t;
    logic             r_up;
    logic [CLR_W-1:0] r_clr;
    logic             r_out_valid;
    logic [LBL_W-1:0] last_l;
    logic [TOP_W-1:0] last_t;
    logic             out_free;
    logic             done;

    assign last_l   = i_nl - 2'd1;
    assign last_t   = TOP_W'(i_nt - 7'd1);
    assign out_free = !r_out_valid || i_out_ready;
    assign done     = i_div_done || i_sts.div_done;

    always_comb begin
        o_cmd.lbl      = r_l;
        o_cmd.top      = r_t;
        o_cmd.clr_addr = r_clr;
        unique case (r_state)
            S_CLEAR:    o_cmd.op = OP_CLR;
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_CNT_RD:   o_cmd.op = OP_CNT_RD;
            S_CNT_WR:   o_cmd.op = r_up ? OP_CNT_UP : OP_CNT_DN;
            S_LBL_RD:   o_cmd.op = OP_LBL_RD;
            S_LBL_DIV:  o_cmd.op = OP_LBL_DIV;
            S_LBL_SAVE: o_cmd.op = OP_LBL_SAVE;
            S_TOP_RD:   o_cmd.op = OP_TOP_RD;
            S_TOP_DIV:  o_cmd.op = OP_TOP_DIV;
            S_MUL1:     o_cmd.op = OP_MUL1;
            S_MUL2:     o_cmd.op = OP_MUL2;
            S_ACC:      o_cmd.op = OP_ACC;
            S_LAST_RD: begin
                o_cmd.op  = OP_WPS_RD;
                o_cmd.lbl = last_l;
                o_cmd.top = last_t;
            end
            S_DRAW:     o_cmd.op = OP_DRAW;
            S_SCAN_RD:  o_cmd.op = OP_WPS_RD;
            S_PICK:     o_cmd.op = OP_PICK;
            S_FINISH:   o_cmd.op = out_free ? OP_OUT : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_l         <= '0;
            r_t         <= '0;
            r_up        <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_FINISH) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_W'(WLT_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_up    <= !i_action;
                        r_state <= S_CNT_RD;
                    end
                end
                S_CNT_RD: r_state <= S_CNT_WR;
                S_CNT_WR: begin
                    if (r_up) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_l     <= '0;
                        r_state <= S_LBL_RD;
                    end
                end
                S_LBL_RD:  r_state <= S_LBL_DIV;
                S_LBL_DIV: r_state <= S_LBL_WAIT;
                S_LBL_WAIT: begin
                    if (done) r_state <= S_LBL_SAVE;
                end
                S_LBL_SAVE: begin
                    r_t     <= '0;
                    r_state <= S_TOP_RD;
                end
                S_TOP_RD:  r_state <= S_TOP_DIV;
                S_TOP_DIV: r_state <= S_TOP_WAIT;
                S_TOP_WAIT: begin
                    if (done) r_state <= S_MUL1;
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_ACC;
                S_ACC: begin
                    if (r_t != last_t) begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_TOP_RD;
                    end else if (r_l != last_l) begin
                        r_l     <= r_l + 1'b1;
                        r_state <= S_LBL_RD;
                    end else begin
                        r_state <= S_LAST_RD;
                    end
                end
                S_LAST_RD: r_state <= S_DRAW;
                S_DRAW: begin
                    r_l     <= '0;
                    r_t     <= '0;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    // stop at the first hit; the last pair is taken when none hits
                    if (i_sts.hit || (r_l == last_l && r_t == last_t)) begin
                        r_state <= S_PICK;
                    end else if (r_t == last_t) begin
                        r_t     <= '0;
                        r_l     <= r_l + 1'b1;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_PICK: begin
                    r_up    <= 1'b1;
                    r_state <= S_CNT_RD;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- sv/joint_sentiment_topic_gibbs_sampler_unit.sv -----
// An assign item passes the count read, count write and finish states before its result is valid;
// a resample item's run time is set by the 16-step restoring dividers that form the three ratios
// of each label/topic pair, one pair at a time.
// One item is in flight at a time; a finished result waits in the output register.
// Reset is synchronous; afterwards a clearing pass zeroes the count
// memories, one entry per cycle, before the first input transfer is taken.
`default_nettype none
module joint_sentiment_topic_gibbs_sampler_unit import stgs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [LBL_W-1:0]  r_label_count;
    logic [NT_W-1:0]   r_topic_count;
    logic [PRI_W-1:0]  r_alpha;
    logic [PRI_W-1:0]  r_gamma;
    logic [BETA_W-1:0] r_beta0, r_beta1, r_beta2;
    t_cfg              cfg;
    t_cmd              cmd;
    t_sts              sts;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count <= LBL_W'(3);
            r_topic_count <= NT_W'(50);
            r_alpha       <= PRI_W'(655);
            r_gamma       <= PRI_W'(65536);
            r_beta0       <= BETA_W'(2684);
            r_beta1       <= BETA_W'(2684);
            r_beta2       <= BETA_W'(2684);
        end else if (wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_LABEL_COUNT: r_label_count <= pwdata[LBL_W-1:0];
                REG_TOPIC_COUNT: r_topic_count <= pwdata[NT_W-1:0];
                REG_ALPHA:       r_alpha       <= pwdata[PRI_W-1:0];
                REG_GAMMA:       r_gamma       <= pwdata[PRI_W-1:0];
                REG_BETA0:       r_beta0       <= pwdata;
                REG_BETA1:       r_beta1       <= pwdata;
                REG_BETA2:       r_beta2       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_LABEL_COUNT: prdata = 32'(r_label_count);
            REG_TOPIC_COUNT: prdata = 32'(r_topic_count);
            REG_ALPHA:       prdata = 32'(r_alpha);
            REG_GAMMA:       prdata = 32'(r_gamma);
            REG_BETA0:       prdata = r_beta0;
            REG_BETA1:       prdata = r_beta1;
            REG_BETA2:       prdata = r_beta2;
            default:         prdata = '0;
        endcase
    end

    // clamp the counts into 1..max
    always_comb begin
        if (r_label_count == '0) cfg.nl = LBL_W'(1);
        else if (r_label_count > LBL_W'(MAX_LABELS)) cfg.nl = LBL_W'(MAX_LABELS);
        else cfg.nl = r_label_count;
        if (r_topic_count == '0) cfg.nt = NT_W'(1);
        else if (r_topic_count > NT_W'(MAX_TOPICS)) cfg.nt = NT_W'(MAX_TOPICS);
        else cfg.nt = r_topic_count;
        cfg.alpha = r_alpha;
        cfg.gamma = r_gamma;
        cfg.beta0 = r_beta0;
        cfg.beta1 = r_beta1;
        cfg.beta2 = r_beta2;
    end

    stgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_in_item.action),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_nl        (cfg.nl),
        .i_nt        (cfg.nt),
        .i_div_done  (1'b0),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stgs_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_item     (i_in_item),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_CLR) |-> !o_in_ready)
        else $error("input taken during clearing pass");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.new_label <= (cfg.nl - 2'd1)) &&
                         ({1'b0, o_out_item.new_topic} <= (cfg.nt - 7'd1))))
        else $error("result outside active label/topic range");

endmodule
`default_nettype wire
